/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk_s, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk_s, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk_s, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk_s, rst_n, cond, msg)

`endif

`endif

/* hdl/asct_pkg.sv */
// ----------------------------------------------------------------------------
// asct_pkg
// Types and constants shared by the SGR colour translator modules.
// ----------------------------------------------------------------------------
package asct_pkg;

	// Queue between parser and serialiser
	localparam int DEF_QUEUE_DEPTH = 4;

	// Output segments of one request, emitted lowest index first
	localparam int SEG_RST  = 0;
	localparam int SEG_BOLD = 1;
	localparam int SEG_FG   = 2;
	localparam int SEG_BG   = 3;
	localparam int SEG_ESC  = 4;
	localparam int SEG_CHAR = 5;
	localparam int SEG_W    = 6;

	// SGR codes with fixed values
	localparam logic [8:0] SGR_RESET = 9'd0;
	localparam logic [8:0] SGR_BOLD  = 9'd1;
	localparam logic [8:0] SGR_FG_BASE = 9'd30;
	localparam logic [8:0] SGR_BG_BASE = 9'd40;

	// Byte values
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BEL   = 8'h07;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_CAN   = 8'h18;
	localparam logic [7:0] CH_SUB   = 8'h1a;
	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_QMARK = 8'h3f;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_J     = 8'h4a;
	localparam logic [7:0] CH_K     = 8'h4b;
	localparam logic [7:0] CH_LBRK  = 8'h5b;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_M     = 8'h6d;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] CH_CSI   = 8'h9b;

	// One request from the parser to the serialiser
	typedef struct packed {
		logic [SEG_W-1:0] seg_mask; // segments to emit
		logic [8:0]       fg_code;  // SGR code of the foreground segment
		logic [8:0]       bg_code;  // SGR code of the background segment
		logic [7:0]       ch;       // byte of the final character segment
	} job_t;

endpackage

/* hdl/asct_front.sv */
// ----------------------------------------------------------------------------
// asct_front
// Escape/CSI parser: tracks colour state and turns each accepted byte into
// at most one serialiser request.
// ----------------------------------------------------------------------------
module asct_front
	import asct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       q_full,
	input  logic       cmd,
	input  logic [7:0] in_byte,
	output logic       job_push,
	output job_t       job
);

	typedef enum logic [2:0] {
		PS_TEXT,
		PS_ESC,
		PS_CSI,
		PS_PARAM,
		PS_BRACKET,
		PS_PRIV,
		PS_PRIV_DONE
	} pstate_t;

	typedef struct packed {
		logic [7:0] fg;
		logic [7:0] bg;
		logic [7:0] prm;
	} colour_t;

	pstate_t    state_q, state_d;
	logic       change_q, change_d;
	logic       armed_q, armed_d;
	logic [7:0] cur_fg_q, cur_fg_d;
	logic [7:0] cur_bg_q, cur_bg_d;
	logic [7:0] pend_fg_q, pend_fg_d;
	logic [7:0] pend_bg_q, pend_bg_d;
	logic [7:0] param_q, param_d;

	logic       accept;
	colour_t    base;
	colour_t    pushed;
	colour_t    priv;
	logic [11:0] acc;
	logic [7:0] acc_sat;
	logic       is_digit;
	logic       fg_on, bg_on;
	logic [7:0] fg_low;

	// Recompute pending colours from the current ones for one parameter
	function automatic colour_t push_param(input logic [7:0] x, input logic [7:0] cfg,
			input logic [7:0] cbg);
		colour_t r;
		r.fg  = cfg;
		r.bg  = cbg;
		r.prm = x;
		if (x == 8'd0) begin
			r.fg = 8'd7;
			r.bg = 8'd0;
		end else if (x == 8'd1) begin
			r.fg = (cfg >= 8'd248) ? 8'hff : cfg + 8'd8;
		end else if (x >= 8'd40) begin
			r.bg = x - 8'd40;
		end else if (x >= 8'd30) begin
			r.fg = ((cfg >= 8'd8) ? 8'd8 : 8'd0) + x - 8'd30;
		end
		return r;
	endfunction

	assign accept   = push && !q_full;
	assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);

	// Pending colours and parameter seen by the parameter parser
	always_comb begin
		if (state_q == PS_CSI) begin
			base = push_param(8'd0, cur_fg_q, cur_bg_q);
		end else begin
			base.fg  = pend_fg_q;
			base.bg  = pend_bg_q;
			base.prm = param_q;
		end
	end

	// Decimal accumulate with saturation
	assign acc     = ({4'd0, base.prm} << 3) + ({4'd0, base.prm} << 1)
		+ {4'd0, in_byte - CH_ZERO};
	assign acc_sat = (acc > 12'd255) ? 8'hff : acc[7:0];
	assign pushed  = push_param(is_digit ? acc_sat : 8'd0, cur_fg_q, cur_bg_q);

	// Private parameter byte taken as a parameter value
	assign priv = push_param(in_byte, cur_fg_q, cur_bg_q);

	// Flush decision on the pending colours
	assign fg_on  = pend_fg_q != 8'd7;
	assign bg_on  = pend_bg_q != 8'd0;
	assign fg_low = (pend_fg_q >= 8'd8) ? pend_fg_q - 8'd8 : pend_fg_q;

	// Parse one byte and build its request
	always_comb begin
		state_d   = state_q;
		change_d  = change_q;
		armed_d   = armed_q;
		cur_fg_d  = cur_fg_q;
		cur_bg_d  = cur_bg_q;
		pend_fg_d = pend_fg_q;
		pend_bg_d = pend_bg_q;
		param_d   = param_q;
		job_push  = 1'b0;
		job.seg_mask = '0;
		job.fg_code  = {1'b0, fg_low} + SGR_FG_BASE;
		job.bg_code  = {1'b0, pend_bg_q} + SGR_BG_BASE;
		job.ch       = in_byte;

		if (accept) begin
			if (cmd) begin
				// End of text: reset tag, NUL, restart
				job_push = 1'b1;
				job.seg_mask[SEG_RST]  = armed_q;
				job.seg_mask[SEG_CHAR] = 1'b1;
				job.ch    = CH_NUL;
				state_d   = PS_TEXT;
				change_d  = 1'b0;
				armed_d   = 1'b0;
				cur_fg_d  = 8'd7;
				cur_bg_d  = 8'd0;
				pend_fg_d = 8'd7;
				pend_bg_d = 8'd0;
				param_d   = 8'd0;
			end else if (in_byte == CH_CAN || in_byte == CH_SUB) begin
				state_d = PS_TEXT;
			end else if (in_byte == CH_ESC) begin
				state_d = PS_ESC;
			end else if (in_byte == CH_CSI) begin
				state_d = PS_CSI;
			end else if (in_byte == CH_BEL || in_byte == CH_NUL || in_byte == CH_DEL ||
					in_byte == CH_VT || in_byte == CH_CR || in_byte == CH_FF) begin
				// Drop silently
			end else begin
				case (state_q)
					PS_TEXT: begin
						job_push = 1'b1;
						job.seg_mask[SEG_CHAR] = 1'b1;
						if (change_q) begin
							job.seg_mask[SEG_RST]  = armed_q;
							job.seg_mask[SEG_BOLD] = fg_on && (pend_fg_q >= 8'd8);
							job.seg_mask[SEG_FG]   = fg_on;
							job.seg_mask[SEG_BG]   = bg_on;
							armed_d  = fg_on || bg_on;
							change_d = 1'b0;
						end
						if (in_byte == CH_TAB) begin
							job.seg_mask[SEG_ESC] = 1'b1;
							job.ch = CH_T;
						end else if (in_byte == CH_DQUOTE || in_byte == CH_BSLASH ||
								in_byte == CH_SLASH) begin
							job.seg_mask[SEG_ESC] = 1'b1;
						end
					end
					PS_ESC: begin
						if (in_byte == CH_LBRK) begin
							state_d = PS_CSI;
						end else if (in_byte == CH_EQ || in_byte == CH_GT || in_byte == CH_H) begin
							state_d = PS_TEXT;
						end
					end
					PS_CSI, PS_PARAM: begin
						if (state_q == PS_CSI &&
								(in_byte == CH_K || in_byte == CH_H || in_byte == CH_J)) begin
							state_d = PS_TEXT;
						end else if (state_q == PS_CSI && in_byte == CH_QMARK) begin
							state_d = PS_PRIV;
						end else begin
							// Parameter bytes, with the implicit leading zero after CSI
							pend_fg_d = base.fg;
							pend_bg_d = base.bg;
							param_d   = base.prm;
							state_d   = PS_PARAM;
							if (in_byte == CH_M) begin
								if (cur_bg_q != base.bg || cur_fg_q != base.fg) begin
									cur_fg_d = base.fg;
									cur_bg_d = base.bg;
									param_d  = 8'd0;
									change_d = 1'b1;
								end
								state_d = PS_TEXT;
							end else if (in_byte == CH_LBRK) begin
								state_d = PS_BRACKET;
							end else if (in_byte == CH_SEMI || is_digit) begin
								pend_fg_d = pushed.fg;
								pend_bg_d = pushed.bg;
								param_d   = pushed.prm;
							end else begin
								state_d = PS_TEXT;
							end
						end
					end
					PS_PRIV: begin
						pend_fg_d = priv.fg;
						pend_bg_d = priv.bg;
						param_d   = priv.prm;
						state_d   = PS_PRIV_DONE;
					end
					default: begin
						state_d = PS_TEXT;
					end
				endcase
			end
		end
	end

	// Hold parser state and colours
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= PS_TEXT;
			change_q  <= 1'b0;
			armed_q   <= 1'b0;
			cur_fg_q  <= 8'd7;
			cur_bg_q  <= 8'd0;
			pend_fg_q <= 8'd7;
			pend_bg_q <= 8'd0;
			param_q   <= 8'd0;
		end else begin
			state_q   <= state_d;
			change_q  <= change_d;
			armed_q   <= armed_d;
			cur_fg_q  <= cur_fg_d;
			cur_bg_q  <= cur_bg_d;
			pend_fg_q <= pend_fg_d;
			pend_bg_q <= pend_bg_d;
			param_q   <= param_d;
		end
	end

endmodule

/* hdl/asct_queue.sv */
// ----------------------------------------------------------------------------
// asct_queue
// Small request queue between the parser and the serialiser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asct_queue
	import asct_pkg::*;
#(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = count_q == FULL_CNT;
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store incoming request
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > FULL_CNT, "queue count beyond depth")
	`ASSERT_AT(a_push_lands, clk, arst_n, (do_push && !do_pop) |=> !empty,
		"queue empty after a push")

endmodule

/* hdl/asct_back.sv */
// ----------------------------------------------------------------------------
// asct_back
// Serialiser: expands the request at the queue head into output bytes,
// one byte per cycle while the output register is free or popped, into a single output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asct_back
	import asct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       q_empty,
	output logic       q_pop,
	output logic [7:0] out_byte,
	output logic       last,
	output logic       empty,
	input  logic       pop
);

	// Byte positions inside one SGR sequence
	localparam logic [2:0] SP_ESC = 3'd0;
	localparam logic [2:0] SP_BRK = 3'd1;
	localparam logic [2:0] SP_HUN = 3'd2;
	localparam logic [2:0] SP_TEN = 3'd3;
	localparam logic [2:0] SP_ONE = 3'd4;
	localparam logic [2:0] SP_END = 3'd5;

	logic             started_q;
	logic [SEG_W-1:0] mask_q;
	logic [2:0]       pos_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic [SEG_W-1:0] cur_mask;
	logic [SEG_W-1:0] seg_oh;
	logic [SEG_W-1:0] rest_mask;
	logic [2:0]       cur_pos;
	logic [2:0]       nxt_pos;
	logic [8:0]       sgr_val;
	logic [1:0]       hun;
	logic [8:0]       rem9;
	logic [6:0]       rem;
	logic [14:0]      prod;
	logic [3:0]       tens;
	logic [6:0]       tens10;
	logic [6:0]       ones7;
	logic             is_sgr;
	logic             seg_done;
	logic             final_byte;
	logic             slot_free;
	logic             advance;
	logic [7:0]       byte_d;

	// Current segment is the lowest one still to emit
	assign cur_mask  = started_q ? mask_q : head.seg_mask;
	assign cur_pos   = started_q ? pos_q : SP_ESC;
	assign seg_oh    = cur_mask & (~cur_mask + 1'b1);
	assign rest_mask = cur_mask & ~seg_oh;
	assign is_sgr    = seg_oh[SEG_RST] | seg_oh[SEG_BOLD] | seg_oh[SEG_FG] | seg_oh[SEG_BG];

	// Select the SGR code of the current segment
	always_comb begin
		if (seg_oh[SEG_BOLD]) begin
			sgr_val = SGR_BOLD;
		end else if (seg_oh[SEG_FG]) begin
			sgr_val = head.fg_code;
		end else if (seg_oh[SEG_BG]) begin
			sgr_val = head.bg_code;
		end else begin
			sgr_val = SGR_RESET;
		end
	end

	// Split into decimal digits; tens by reciprocal multiply
	assign hun    = (sgr_val >= 9'd200) ? 2'd2 : ((sgr_val >= 9'd100) ? 2'd1 : 2'd0);
	assign rem9   = sgr_val - ((sgr_val >= 9'd200) ? 9'd200 : ((sgr_val >= 9'd100) ? 9'd100 : 9'd0));
	assign rem    = rem9[6:0];
	assign prod   = 15'(rem) * 15'd205;
	assign tens   = prod[14:11];
	assign tens10 = ({3'd0, tens} << 3) + ({3'd0, tens} << 1);
	assign ones7  = rem - tens10;

	// Pick the byte at the current position
	always_comb begin
		if (seg_oh[SEG_ESC]) begin
			byte_d = CH_BSLASH;
		end else if (seg_oh[SEG_CHAR]) begin
			byte_d = head.ch;
		end else begin
			case (cur_pos)
				SP_ESC:  byte_d = CH_ESC;
				SP_BRK:  byte_d = CH_LBRK;
				SP_HUN:  byte_d = CH_ZERO + {6'd0, hun};
				SP_TEN:  byte_d = CH_ZERO + {4'd0, tens};
				SP_ONE:  byte_d = CH_ZERO + {4'd0, ones7[3:0]};
				default: byte_d = CH_M;
			endcase
		end
	end

	// Skip leading zero digits
	always_comb begin
		if (cur_pos == SP_BRK) begin
			if (sgr_val >= 9'd100) begin
				nxt_pos = SP_HUN;
			end else if (sgr_val >= 9'd10) begin
				nxt_pos = SP_TEN;
			end else begin
				nxt_pos = SP_ONE;
			end
		end else begin
			nxt_pos = cur_pos + 3'd1;
		end
	end

	assign seg_done   = !is_sgr || (cur_pos == SP_END);
	assign final_byte = seg_done && (rest_mask == '0);
	assign slot_free  = !out_valid_q || pop;
	assign advance    = !q_empty && slot_free;
	assign q_pop      = advance && final_byte;

	// Advance the sequencer and load the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			mask_q      <= '0;
			pos_q       <= SP_ESC;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				started_q   <= !final_byte;
				mask_q      <= seg_done ? rest_mask : cur_mask;
				pos_q       <= seg_done ? SP_ESC : nxt_pos;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= byte_d;
			out_last_q <= final_byte;
		end
	end

	assign out_byte = out_byte_q;
	assign last     = out_last_q;
	assign empty    = !out_valid_q;

	`ASSERT_AT(a_started_has_head, clk, arst_n, started_q |-> !q_empty,
		"request in progress but queue empty")
	`ASSERT_AT(a_started_has_segs, clk, arst_n, started_q |-> (mask_q != '0),
		"request in progress with no segments left")

endmodule

/* hdl/ansi_sgr_color_translator.sv */
// ----------------------------------------------------------------------------
// ansi_sgr_color_translator
// Translates text with ANSI escape/CSI sequences into canonical SGR colour
// codes and backslash-escaped characters.
// ----------------------------------------------------------------------------
// Each input request is parsed in the cycle it is accepted; plain text runs at
// one byte per cycle while full is low. A request that expands to k output
// bytes, up to 22 (colour flush, escaped character, end of text with reset
// tag), keeps the serialiser busy, one output byte per cycle while the
// receiver pops. Dropped control bytes and escape bytes produce no output. A
// queue of QUEUE_DEPTH requests sits between parser and serialiser, so input
// keeps flowing while a long expansion drains; full rises only when that queue is full.
module ansi_sgr_color_translator
	import asct_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       cmd,
	input  logic [7:0] in_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last
);

	logic job_push;
	job_t job;
	logic q_full;
	logic q_empty;
	logic q_pop;
	job_t head;

	assign full = q_full;

	// Parser
	asct_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.q_full   (q_full),
		.cmd      (cmd),
		.in_byte  (in_byte),
		.job_push (job_push),
		.job      (job)
	);

	// Request queue
	asct_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (head)
	);

	// Serialiser
	asct_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.out_byte (out_byte),
		.last     (last),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

/* dv/ansi_sgr_color_translator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_sgr_color_translator_tb
// Drives text bytes and end-of-text requests into the SGR colour translator
// and checks every output byte and its last flag against a predictor of the
// parser (typed table rows carry their own). A short directed table comes
// first, then random escape sequences, text and control bytes, with idle
// bursts on both sides and one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module ansi_sgr_color_translator_tb;
	import asct_pkg::*;

	localparam logic CMD_TEXT = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam int FG_DEFAULT   = 7;
	localparam int BG_DEFAULT   = 0;
	localparam int BOLD_STEP    = 8;
	localparam int PARAM_MAX    = 255;
	localparam int RANDOM_ITEMS = 500;
	localparam int QUIET_ITEMS  = 80;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int REPORT_MAX   = 10;

	typedef enum logic [2:0] {
		PS_TEXT, PS_ESC, PS_CSI, PS_PARAM, PS_SKIP_BRK, PS_PRIV, PS_PRIV_DONE
	} parse_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} out_t;

	typedef struct packed {
		logic       c;
		logic [7:0] b;
		logic       typed;
		logic [1:0] n;
		logic [7:0] e0;
		logic [7:0] e1;
	} stim_row_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       push     = 1'b0;
	logic       full;
	logic       cmd      = CMD_TEXT;
	logic [7:0] in_byte  = 8'h00;
	logic       empty;
	logic       pop      = 1'b0;
	logic [7:0] out_byte;
	logic       last;

	// Predictor state
	parse_t     ps;
	logic       change_armed;
	logic [7:0] fg_now, bg_now, fg_next, bg_next, acc;
	logic       tag_armed;
	logic [7:0] pred_bytes[$];

	out_t       expected_bytes[$];
	stim_row_t  table_rows[$];
	int         fail_count  = 0;
	int         items_sent  = 0;
	int         cycle_count = 0;
	logic       quiet       = 1'b0;
	logic       rx_hold     = 1'b0;
	int         rx_gap      = 0;

	ansi_sgr_color_translator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.cmd      (cmd),
		.in_byte  (in_byte),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.last     (last)
	);

	// Clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	task automatic clear_parser();
		ps           = PS_TEXT;
		change_armed = 1'b0;
		fg_now       = 8'(FG_DEFAULT);
		bg_now       = 8'(BG_DEFAULT);
		fg_next      = 8'(FG_DEFAULT);
		bg_next      = 8'(BG_DEFAULT);
		acc          = 8'd0;
		tag_armed    = 1'b0;
	endtask

	task automatic emit_sgr(input int v);
		pred_bytes.push_back(CH_ESC);
		pred_bytes.push_back(CH_LBRK);
		if (v >= 100)
			pred_bytes.push_back(8'(int'(CH_ZERO) + (v / 100) % 10));
		if (v >= 10)
			pred_bytes.push_back(8'(int'(CH_ZERO) + (v / 10) % 10));
		pred_bytes.push_back(8'(int'(CH_ZERO) + v % 10));
		pred_bytes.push_back(CH_M);
	endtask

	// Recompute the pending colours from the current ones
	task automatic apply_param(input int x);
		int f;
		int g;
		f = fg_now;
		g = bg_now;
		if (x > PARAM_MAX)
			x = PARAM_MAX;
		if (x == int'(SGR_RESET)) begin
			f = FG_DEFAULT;
			g = BG_DEFAULT;
		end else if (x == int'(SGR_BOLD)) begin
			f = (f + BOLD_STEP > PARAM_MAX) ? PARAM_MAX : f + BOLD_STEP;
		end else if (x >= int'(SGR_BG_BASE)) begin
			g = x - int'(SGR_BG_BASE);
		end else if (x >= int'(SGR_FG_BASE)) begin
			f = ((f >= BOLD_STEP) ? BOLD_STEP : 0) + x - int'(SGR_FG_BASE);
		end
		fg_next = 8'(f);
		bg_next = 8'(g);
		acc     = 8'(x);
	endtask

	task automatic param_char(input logic [7:0] ch);
		if (ch == CH_M) begin
			if (bg_now != bg_next || fg_now != fg_next) begin
				fg_now       = fg_next;
				bg_now       = bg_next;
				acc          = 8'd0;
				change_armed = 1'b1;
			end
			ps = PS_TEXT;
		end else if (ch == CH_LBRK) begin
			ps = PS_SKIP_BRK;
		end else if (ch == CH_SEMI) begin
			apply_param(0);
		end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
			apply_param(int'(acc) * 10 + int'(ch) - int'(CH_ZERO));
		end else begin
			ps = PS_TEXT;
		end
	endtask

	task automatic flush_colours();
		int  f;
		logic fg_on;
		logic bg_on;
		fg_on = fg_next != 8'(FG_DEFAULT);
		bg_on = bg_next != 8'(BG_DEFAULT);
		if (tag_armed)
			emit_sgr(int'(SGR_RESET));
		if (fg_on || bg_on) begin
			if (fg_on) begin
				f = fg_next;
				if (f >= BOLD_STEP) begin
					emit_sgr(int'(SGR_BOLD));
					f = f - BOLD_STEP;
				end
				emit_sgr(f + int'(SGR_FG_BASE));
			end
			if (bg_on)
				emit_sgr(int'(bg_next) + int'(SGR_BG_BASE));
			tag_armed = 1'b1;
		end else begin
			tag_armed = 1'b0;
		end
	endtask

	task automatic text_char(input logic [7:0] ch);
		if (change_armed) begin
			flush_colours();
			change_armed = 1'b0;
		end
		if (ch == CH_TAB) begin
			pred_bytes.push_back(CH_BSLASH);
			pred_bytes.push_back(CH_T);
		end else if (ch == CH_DQUOTE || ch == CH_BSLASH || ch == CH_SLASH) begin
			pred_bytes.push_back(CH_BSLASH);
			pred_bytes.push_back(ch);
		end else begin
			pred_bytes.push_back(ch);
		end
	endtask

	// Work out the output bytes of one accepted request
	task automatic translate_item(input logic c, input logic [7:0] b);
		pred_bytes.delete();
		if (c == CMD_END) begin
			if (tag_armed)
				emit_sgr(int'(SGR_RESET));
			pred_bytes.push_back(CH_NUL);
			clear_parser();
		end else if (b == CH_CAN || b == CH_SUB) begin
			ps = PS_TEXT;
		end else if (b == CH_ESC) begin
			ps = PS_ESC;
		end else if (b == CH_CSI) begin
			ps = PS_CSI;
		end else if (!(b == CH_BEL || b == CH_NUL || b == CH_DEL || b == CH_VT ||
				b == CH_CR || b == CH_FF)) begin
			case (ps)
				PS_TEXT: text_char(b);
				PS_ESC: begin
					if (b == CH_LBRK)
						ps = PS_CSI;
					else if (b == CH_EQ || b == CH_GT || b == CH_H)
						ps = PS_TEXT;
				end
				PS_CSI: begin
					if (b == CH_K || b == CH_H || b == CH_J) begin
						ps = PS_TEXT;
					end else if (b == CH_QMARK) begin
						ps = PS_PRIV;
					end else begin
						apply_param(0);
						ps = PS_PARAM;
						param_char(b);
					end
				end
				PS_PARAM: param_char(b);
				PS_PRIV: begin
					apply_param(int'(b));
					ps = PS_PRIV_DONE;
				end
				default: ps = PS_TEXT;
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic check_result(input logic [7:0] ob, input logic ol);
		out_t want;
		if (expected_bytes.size() == 0) begin
			if (fail_count < REPORT_MAX)
				$display("ERROR: unexpected output byte %h last %b", ob, ol);
			fail_count++;
		end else begin
			want = expected_bytes.pop_front();
			if (ob !== want.data || ol !== want.fin) begin
				if (fail_count < REPORT_MAX)
					$display("ERROR: out_byte %h last %b, expected %h last %b",
						ob, ol, want.data, want.fin);
				fail_count++;
			end
		end
	endtask

	// Accept results, and pop with random idle bursts or a long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_result(out_byte, last);
			if (rx_hold) begin
				pop <= 1'b0;
			end else if (rx_gap > 0) begin
				pop    <= 1'b0;
				rx_gap <= rx_gap - 1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				pop    <= 1'b0;
				rx_gap <= $urandom_range(0, 5);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Hold the receiver off once so that the block fills and stalls its input
	initial begin
		wait (items_sent >= HOLD_AT);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	// Offer one request; called and returning at a rising edge
	task automatic send_item(input logic c, input logic [7:0] b, input logic typed,
			input logic [1:0] n, input logic [7:0] e0, input logic [7:0] e1);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		push    <= 1'b1;
		cmd     <= c;
		in_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		translate_item(c, b);
		if (typed) begin
			for (int i = 0; i < n; i++)
				expected_bytes.push_back('{data: (i == 0) ? e0 : e1, fin: i == n - 1});
		end else begin
			foreach (pred_bytes[i])
				expected_bytes.push_back('{data: pred_bytes[i],
					fin: i == pred_bytes.size() - 1});
		end
		items_sent++;
		if (items_sent >= table_rows.size() + RANDOM_ITEMS - QUIET_ITEMS)
			quiet <= 1'b1;
	endtask

	task automatic send_text(input logic [7:0] b);
		send_item(CMD_TEXT, b, 1'b0, 2'd0, 8'h00, 8'h00);
	endtask

	task automatic send_intro();
		if ($urandom_range(0, 1)) begin
			send_text(CH_ESC);
			send_text(CH_LBRK);
		end else begin
			send_text(CH_CSI);
		end
	endtask

	task automatic send_number(input int v);
		if (v >= 100)
			send_text(8'(int'(CH_ZERO) + (v / 100) % 10));
		if (v >= 10)
			send_text(8'(int'(CH_ZERO) + (v / 10) % 10));
		send_text(8'(int'(CH_ZERO) + v % 10));
	endtask

	task automatic send_sgr_param();
		case ($urandom_range(0, 7))
			0: send_number(0);
			1: send_number(1);
			2, 3: send_number($urandom_range(30, 39));
			4, 5: send_number($urandom_range(40, 47));
			6: send_number($urandom_range(0, 255));
			default: send_number($urandom_range(256, 999));
		endcase
	endtask

	task automatic send_plain();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8)
			send_text(8'($urandom_range(32, 126)));
		else if (r == 8)
			case ($urandom_range(0, 3))
				0: send_text(CH_TAB);
				1: send_text(CH_DQUOTE);
				2: send_text(CH_BSLASH);
				default: send_text(CH_SLASH);
			endcase
		else
			send_text(8'($urandom_range(0, 255)));
	endtask

	task automatic send_silent();
		case ($urandom_range(0, 7))
			0: send_text(CH_BEL);
			1: send_text(CH_NUL);
			2: send_text(CH_DEL);
			3: send_text(CH_VT);
			4: send_text(CH_CR);
			5: send_text(CH_FF);
			6: send_text(CH_CAN);
			default: send_text(CH_SUB);
		endcase
	endtask

	// Repeated bold commits raise the foreground, up to saturation at 255
	task automatic send_bold_chain(input int reps);
		repeat (reps) begin
			send_intro();
			send_text(8'(int'(CH_ZERO) + int'(SGR_BOLD)));
			send_text(CH_M);
		end
	endtask

	task automatic send_random_sequence();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 35) begin
			repeat ($urandom_range(1, 8))
				send_plain();
		end else if (kind < 65) begin
			send_intro();
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 9) != 0)
					send_sgr_param();
				send_text(CH_SEMI);
			end
			send_sgr_param();
			if ($urandom_range(0, 9) != 0)
				send_text(CH_M);
			else
				send_text(8'($urandom_range(0, 255)));
			send_plain();
		end else if (kind < 73) begin
			send_intro();
			send_text(CH_QMARK);
			send_text(8'($urandom_range(0, 255)));
			send_text(($urandom_range(0, 1)) ? CH_M : 8'($urandom_range(0, 255)));
			send_plain();
		end else if (kind < 81) begin
			if ($urandom_range(0, 1)) begin
				send_text(CH_ESC);
				case ($urandom_range(0, 3))
					0: send_text(CH_EQ);
					1: send_text(CH_GT);
					2: send_text(CH_H);
					default: send_text(8'($urandom_range(0, 255)));
				endcase
			end else begin
				send_intro();
				case ($urandom_range(0, 2))
					0: send_text(CH_K);
					1: send_text(CH_H);
					default: send_text(CH_J);
				endcase
			end
			send_plain();
		end else if (kind < 89) begin
			send_intro();
			send_sgr_param();
			send_silent();
			send_text(CH_M);
			send_silent();
			send_plain();
		end else if (kind < 94) begin
			send_intro();
			send_sgr_param();
			send_text(CH_LBRK);
			send_text(8'($urandom_range(0, 255)));
			send_plain();
		end else if (kind < 98) begin
			send_item(CMD_END, 8'($urandom_range(0, 255)), 1'b0, 2'd0, 8'h00, 8'h00);
		end else begin
			send_bold_chain($urandom_range(2, 6));
			send_plain();
		end
	endtask

	task automatic add_row(input logic c, input logic [7:0] b, input logic typed,
			input logic [1:0] n, input logic [7:0] e0, input logic [7:0] e1);
		table_rows.push_back('{c: c, b: b, typed: typed, n: n, e0: e0, e1: e1});
	endtask

	// Main sequence
	initial begin
		clear_parser();

		// Directed table: typed rows carry their own expectation
		add_row(CMD_TEXT, 8'h41,     1'b1, 2'd1, 8'h41, 8'h00);
		add_row(CMD_TEXT, CH_TAB,    1'b1, 2'd2, CH_BSLASH, CH_T);
		add_row(CMD_TEXT, CH_DQUOTE, 1'b1, 2'd2, CH_BSLASH, CH_DQUOTE);
		add_row(CMD_TEXT, CH_BSLASH, 1'b1, 2'd2, CH_BSLASH, CH_BSLASH);
		add_row(CMD_TEXT, CH_SLASH,  1'b1, 2'd2, CH_BSLASH, CH_SLASH);
		add_row(CMD_TEXT, CH_NUL,    1'b1, 2'd0, 8'h00, 8'h00);
		add_row(CMD_TEXT, 8'hff,     1'b1, 2'd1, 8'hff, 8'h00);
		// Bold commit, then a control byte must not flush it
		add_row(CMD_TEXT, CH_ESC,    1'b0, 2'd0, 8'h00, 8'h00);
		add_row(CMD_TEXT, CH_LBRK,   1'b0, 2'd0, 8'h00, 8'h00);
		add_row(CMD_TEXT, 8'h31,     1'b0, 2'd0, 8'h00, 8'h00);
		add_row(CMD_TEXT, CH_M,      1'b0, 2'd0, 8'h00, 8'h00);
		add_row(CMD_TEXT, CH_BEL,    1'b1, 2'd0, 8'h00, 8'h00);
		add_row(CMD_TEXT, 8'h78,     1'b0, 2'd0, 8'h00, 8'h00);
		// Saturating parameter gives the widest background code
		add_row(CMD_TEXT, CH_CSI,    1'b0, 2'd0, 8'h00, 8'h00);
		add_row(CMD_TEXT, CH_NINE,   1'b0, 2'd0, 8'h00, 8'h00);
		add_row(CMD_TEXT, CH_NINE,   1'b0, 2'd0, 8'h00, 8'h00);
		add_row(CMD_TEXT, CH_NINE,   1'b0, 2'd0, 8'h00, 8'h00);
		add_row(CMD_TEXT, CH_M,      1'b0, 2'd0, 8'h00, 8'h00);
		add_row(CMD_TEXT, 8'h79,     1'b0, 2'd0, 8'h00, 8'h00);
		// Private parameter byte, cancelled back to text
		add_row(CMD_TEXT, CH_CSI,    1'b0, 2'd0, 8'h00, 8'h00);
		add_row(CMD_TEXT, CH_QMARK,  1'b0, 2'd0, 8'h00, 8'h00);
		add_row(CMD_TEXT, 8'h80,     1'b0, 2'd0, 8'h00, 8'h00);
		add_row(CMD_TEXT, CH_CAN,    1'b0, 2'd0, 8'h00, 8'h00);
		// End with the reset tag armed, then end straight after restart
		add_row(CMD_END,  8'hff,     1'b0, 2'd0, 8'h00, 8'h00);
		add_row(CMD_END,  8'h00,     1'b1, 2'd1, CH_NUL, 8'h00);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i])
			send_item(table_rows[i].c, table_rows[i].b, table_rows[i].typed,
				table_rows[i].n, table_rows[i].e0, table_rows[i].e1);

		// Saturate the foreground once, with a pending change left at end of text
		send_bold_chain(32);
		send_text(8'h5a);
		send_intro();
		send_number(41);
		send_text(CH_M);
		send_item(CMD_END, 8'h00, 1'b0, 2'd0, 8'h00, 8'h00);

		while (items_sent < table_rows.size() + RANDOM_ITEMS)
			send_random_sequence();
		push <= 1'b0;

		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && expected_bytes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
